// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks shared by the link LED monitor modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== design/lllm_pkg.sv =====
// ----------------------------------------------------------------------------
// Link latency LED monitor package
// Types, constants and the LED output helper shared by the monitor modules.
// ----------------------------------------------------------------------------
package lllm_pkg;

    localparam int PWM_STEPS = 32;
    localparam int PWM_W     = $clog2(PWM_STEPS + 1);
    localparam int SET_W     = 11;
    localparam int PADDR_W   = 5;
    localparam int RES_DEPTH = 4;

    localparam logic [15:0] BLINK_FIRST = 16'd32000;
    localparam logic [15:0] BLINK_ON    = 16'd2400;
    localparam logic [15:0] BLINK_RESET = 16'd24000;
    localparam logic [13:0] TEST_PERIOD = 14'd12000;
    localparam logic [7:0]  TEST_COLOR_RESET = 8'hFF;

    localparam logic [7:0] C_OFF     = 8'd0;
    localparam logic [7:0] C_BLUE    = 8'd1;
    localparam logic [7:0] C_GREEN   = 8'd2;
    localparam logic [7:0] C_CYAN    = 8'd3;
    localparam logic [7:0] C_RED     = 8'd4;
    localparam logic [7:0] C_MAGENTA = 8'd5;
    localparam logic [7:0] C_YELLOW  = 8'd6;

    localparam logic [1:0] BR_DIM    = 2'd0;
    localparam logic [1:0] BR_NORMAL = 2'd1;
    localparam logic [1:0] BR_BRIGHT = 2'd2;

    typedef enum logic [3:0] {
        EV_TEST      = 4'd0,
        EV_DISABLE   = 4'd1,
        EV_UNPOWERED = 4'd2,
        EV_POWERED   = 4'd3,
        EV_OFFLINE   = 4'd4,
        EV_ONLINE    = 4'd5,
        EV_DROP_IN   = 4'd6,
        EV_START     = 4'd7,
        EV_DELIVERED = 4'd8,
        EV_DROPPED   = 4'd9
    } ev_code_e;

    typedef enum logic [2:0] {
        REG_LATE_TICKS     = 3'd0,
        REG_STALE_TICKS    = 3'd1,
        REG_HOT_HOLD       = 3'd2,
        REG_DROPPED_HOT    = 3'd3,
        REG_LATE_HOLD      = 3'd4,
        REG_STALE_HOLD     = 3'd5,
        REG_DROPPED_HOLD   = 3'd6,
        REG_BLINK_PERIOD   = 3'd7
    } reg_idx_e;

    typedef enum logic [1:0] {
        LAT_REALTIME = 2'd0,
        LAT_LATE     = 2'd1,
        LAT_STALE    = 2'd2,
        LAT_DROPPED  = 2'd3
    } lat_class_e;

    typedef struct packed {
        logic       func;
        logic       port;
        logic [3:0] event_req;
        logic       version_shown;
    } in_t;

    typedef struct packed {
        logic       led_port;
        logic [7:0] led_color;
        logic       last;
    } out_t;

    typedef struct packed {
        logic [15:0] late_ticks;
        logic [15:0] stale_ticks;
        logic [15:0] hot_hold_ticks;
        logic [15:0] dropped_hot_ticks;
        logic [15:0] late_hold_ticks;
        logic [15:0] stale_hold_ticks;
        logic [15:0] dropped_hold_ticks;
        logic [15:0] blink_period_ticks;
    } cfg_t;

    typedef struct packed {
        logic     tick;
        logic     evt;
        ev_code_e code;
    } port_ctl_t;

    typedef struct packed {
        logic [1:0] cnt;
        out_t       r0;
        out_t       r1;
    } res_push_t;

    function automatic logic [7:0] shown_color(
        input logic [SET_W-1:0] setting,
        input logic [PWM_W-1:0] pwm,
        input logic [15:0]      blink_cnt,
        input logic [15:0]      period
    );
        logic        lit;
        logic [15:0] off_len;
        off_len = (period > BLINK_ON) ? period - BLINK_ON : 16'd0;
        case (setting[9:8])
            BR_DIM:    lit = (pwm == PWM_W'(PWM_STEPS));
            BR_NORMAL: lit = (pwm[2:0] == 3'd0);
            default:   lit = 1'b1;
        endcase
        if (setting[10] && (blink_cnt < off_len))
        begin
            lit = 1'b0;
        end
        return lit ? setting[7:0] : C_OFF;
    endfunction

endpackage

// ===== design/lllm_port.sv =====
// ----------------------------------------------------------------------------
// Link LED monitor port tracker
// Per-port status, packet age, latency class and hold timers; picks the LED
// setting for the port on each tick and packet start.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lllm_port (
    input  logic                     clk,
    input  logic                     rst_n,
    input  lllm_pkg::cfg_t           cfg,
    input  lllm_pkg::port_ctl_t      ctl,
    output logic [lllm_pkg::SET_W-1:0] setting
);
    import lllm_pkg::*;

    logic        powered_reg, powered_next;
    logic        online_reg, online_next;
    logic [15:0] age_reg, age_next;
    lat_class_e  class_reg, class_next;
    logic        dp_reg, dp_next;
    logic [15:0] hot_reg, hot_next;
    logic [15:0] late_reg, late_next;
    logic [15:0] stale_reg, stale_next;
    logic [15:0] dropped_reg, dropped_next;

    logic        start;
    logic        choose;
    logic [15:0] age_in;
    logic [15:0] c_hot, c_late, c_stale, c_dropped;
    lat_class_e  c_class;
    logic        c_dp;

    assign start  = ctl.evt && (ctl.code == EV_START);
    assign choose = ctl.tick || start;
    assign age_in = start ? 16'd1 : age_reg;

    always_comb
    begin
        c_hot     = hot_reg;
        c_late    = late_reg;
        c_stale   = stale_reg;
        c_dropped = dropped_reg;
        c_class   = class_reg;
        c_dp      = dp_reg;
        setting   = '0;
        if (!online_reg)
        begin
            setting = {1'b1, BR_DIM, (powered_reg ? C_CYAN : C_BLUE)};
        end
        else if (age_in != 16'd0)
        begin
            c_hot = cfg.hot_hold_ticks;
            if (age_in < cfg.late_ticks)
            begin
                c_class = LAT_REALTIME;
            end
            else if (age_in < cfg.stale_ticks)
            begin
                c_class = LAT_LATE;
                c_late  = cfg.late_hold_ticks;
            end
            else
            begin
                c_class = LAT_STALE;
                c_stale = cfg.stale_hold_ticks;
            end
            case (c_class)
                LAT_REALTIME:
                begin
                    if (dropped_reg != 16'd0)
                        setting = {1'b0, BR_BRIGHT, C_MAGENTA};
                    else if (stale_reg != 16'd0)
                        setting = {1'b0, BR_BRIGHT, C_RED};
                    else if (late_reg != 16'd0)
                        setting = {1'b0, BR_BRIGHT, C_YELLOW};
                    else
                        setting = {1'b0, BR_BRIGHT, C_CYAN};
                end
                LAT_LATE: setting = {1'b0, BR_BRIGHT, C_YELLOW};
                default:  setting = {1'b0, BR_BRIGHT, C_RED};
            endcase
        end
        else
        begin
            if (dp_reg)
            begin
                c_dp      = 1'b0;
                c_hot     = cfg.dropped_hot_ticks;
                c_dropped = cfg.dropped_hold_ticks;
                c_class   = LAT_DROPPED;
            end
            if (c_hot != 16'd0)
            begin
                case (c_class)
                    LAT_REALTIME: setting = {1'b0, BR_NORMAL, C_GREEN};
                    LAT_LATE:     setting = {1'b0, BR_NORMAL, C_YELLOW};
                    LAT_STALE:    setting = {1'b0, BR_NORMAL, C_RED};
                    default:      setting = {1'b0, BR_BRIGHT, C_MAGENTA};
                endcase
            end
            else if (c_dropped != 16'd0)
                setting = {1'b0, BR_NORMAL, C_MAGENTA};
            else if (c_stale != 16'd0)
                setting = {1'b0, BR_DIM, C_RED};
            else if (c_late != 16'd0)
                setting = {1'b0, BR_DIM, C_YELLOW};
            else
                setting = {1'b0, BR_DIM, C_GREEN};
        end
    end

    always_comb
    begin
        powered_next = powered_reg;
        online_next  = online_reg;
        age_next     = age_reg;
        class_next   = class_reg;
        dp_next      = dp_reg;
        hot_next     = hot_reg;
        late_next    = late_reg;
        stale_next   = stale_reg;
        dropped_next = dropped_reg;
        if (choose)
        begin
            class_next   = c_class;
            dp_next      = c_dp;
            hot_next     = c_hot;
            late_next    = c_late;
            stale_next   = c_stale;
            dropped_next = c_dropped;
        end
        if (ctl.tick)
        begin
            if (online_reg && (age_reg != 16'd0) && (age_reg != 16'hFFFF))
                age_next = age_reg + 16'd1;
            if (c_hot != 16'd0)
                hot_next = c_hot - 16'd1;
            if (c_late != 16'd0)
                late_next = c_late - 16'd1;
            if (c_stale != 16'd0)
                stale_next = c_stale - 16'd1;
            if (c_dropped != 16'd0)
                dropped_next = c_dropped - 16'd1;
        end
        if (ctl.evt)
        begin
            unique case (ctl.code)
                EV_UNPOWERED: powered_next = 1'b0;
                EV_POWERED:   powered_next = 1'b1;
                EV_OFFLINE:   online_next  = 1'b0;
                EV_ONLINE:    online_next  = 1'b1;
                EV_DROP_IN:   dp_next      = 1'b1;
                EV_START:     age_next     = 16'd1;
                EV_DELIVERED: age_next     = 16'd0;
                EV_DROPPED:
                begin
                    dp_next  = 1'b1;
                    age_next = 16'd0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            powered_reg <= 1'b0;
            online_reg  <= 1'b0;
            age_reg     <= 16'd0;
            class_reg   <= LAT_REALTIME;
            dp_reg      <= 1'b0;
            hot_reg     <= 16'd0;
            late_reg    <= 16'd0;
            stale_reg   <= 16'd0;
            dropped_reg <= 16'd0;
        end
        else
        begin
            powered_reg <= powered_next;
            online_reg  <= online_next;
            age_reg     <= age_next;
            class_reg   <= class_next;
            dp_reg      <= dp_next;
            hot_reg     <= hot_next;
            late_reg    <= late_next;
            stale_reg   <= stale_next;
            dropped_reg <= dropped_next;
        end
    end

    `ASSERT_CLK(a_age_saturates, (ctl.tick && (age_reg == 16'hFFFF)) |=> (age_reg == 16'hFFFF), "packet age wrapped")

endmodule

// ===== design/lllm_out.sv =====
// ----------------------------------------------------------------------------
// Link LED monitor result buffer
// Small queue that takes up to two LED writes a cycle while it has room
// for two; hands out one result-channel transfer a cycle unless stalled.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lllm_out (
    input  logic                clk,
    input  logic                rst_n,
    input  lllm_pkg::res_push_t push,
    output logic                room,
    output logic                out_valid,
    input  logic                out_stall,
    output lllm_pkg::out_t      out_data
);
    import lllm_pkg::*;

    localparam int PTR_W = $clog2(RES_DEPTH);
    localparam int CNT_W = $clog2(RES_DEPTH + 1);

    out_t             ent_reg [RES_DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             pop;

    assign out_valid = (cnt_reg != CNT_W'(0));
    assign out_data  = ent_reg[rd_reg];
    assign pop       = out_valid && !out_stall;
    assign room      = (cnt_reg <= CNT_W'(RES_DEPTH - 2));

    always_comb
    begin
        wr_next  = wr_reg + PTR_W'(push.cnt);
        rd_next  = rd_reg + PTR_W'(pop);
        cnt_next = cnt_reg + CNT_W'(push.cnt) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
        begin
            ent_reg[wr_reg] <= push.r0;
        end
        if (push.cnt == 2'd2)
        begin
            ent_reg[wr_reg + PTR_W'(1)] <= push.r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    `ASSERT_NEVER(a_cnt_bound, cnt_reg > CNT_W'(RES_DEPTH), "result queue count out of range")
    `ASSERT_NEVER(a_no_overflow, (push.cnt != 2'd0) && !room, "write into full result queue")

endmodule

// ===== design/link_latency_led_monitor_core.sv =====
// ----------------------------------------------------------------------------
// Link latency LED monitor core
// Takes one item (a 125 us tick or a port event) per clock, unless in_stall
// holds it, into an input register and works it when the result queue has
// room for two LED writes, taking in the next item meanwhile. A tick gives
// two LED writes unless suppressed outside test mode; with one transfer a
// cycle out of the result channel when unstalled, ticks wait for room and
// events run at one per cycle. Items pass the input register, their writes
// the result queue, which holds four writes. Registers sit on an APB port
// at byte address 4*index; no clearing pass follows reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module link_latency_led_monitor_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  lllm_pkg::in_t                  in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output lllm_pkg::out_t                 out_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lllm_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import lllm_pkg::*;

    cfg_t             cfg_reg;
    in_t              item_reg;
    logic             item_valid_reg;
    logic [PWM_W-1:0] pwm_reg, pwm_next;
    logic [15:0]      blink_reg, blink_next;
    logic             test_mode_reg, test_mode_next;
    logic             disabled_reg, disabled_next;
    logic [7:0]       test_color_reg, test_color_next;
    logic [13:0]      test_cnt_reg, test_cnt_next;

    logic             room;
    logic             process;
    logic             is_tick;
    logic             is_evt;
    logic             suppressed;
    ev_code_e         code;
    port_ctl_t        ctl0, ctl1;
    logic [SET_W-1:0] setting0, setting1;
    logic [7:0]       shown0, shown1;
    res_push_t        push;
    reg_idx_e         reg_idx;
    logic             cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_e'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.late_ticks         <= 16'd3;
            cfg_reg.stale_ticks        <= 16'd16;
            cfg_reg.hot_hold_ticks     <= 16'd160;
            cfg_reg.dropped_hot_ticks  <= 16'd2400;
            cfg_reg.late_hold_ticks    <= 16'd16000;
            cfg_reg.stale_hold_ticks   <= 16'd32000;
            cfg_reg.dropped_hold_ticks <= 16'd48000;
            cfg_reg.blink_period_ticks <= BLINK_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_LATE_TICKS:   cfg_reg.late_ticks         <= pwdata[15:0];
                REG_STALE_TICKS:  cfg_reg.stale_ticks        <= pwdata[15:0];
                REG_HOT_HOLD:     cfg_reg.hot_hold_ticks     <= pwdata[15:0];
                REG_DROPPED_HOT:  cfg_reg.dropped_hot_ticks  <= pwdata[15:0];
                REG_LATE_HOLD:    cfg_reg.late_hold_ticks    <= pwdata[15:0];
                REG_STALE_HOLD:   cfg_reg.stale_hold_ticks   <= pwdata[15:0];
                REG_DROPPED_HOLD: cfg_reg.dropped_hold_ticks <= pwdata[15:0];
                default:          cfg_reg.blink_period_ticks <= pwdata[15:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_LATE_TICKS:   prdata = {16'd0, cfg_reg.late_ticks};
            REG_STALE_TICKS:  prdata = {16'd0, cfg_reg.stale_ticks};
            REG_HOT_HOLD:     prdata = {16'd0, cfg_reg.hot_hold_ticks};
            REG_DROPPED_HOT:  prdata = {16'd0, cfg_reg.dropped_hot_ticks};
            REG_LATE_HOLD:    prdata = {16'd0, cfg_reg.late_hold_ticks};
            REG_STALE_HOLD:   prdata = {16'd0, cfg_reg.stale_hold_ticks};
            REG_DROPPED_HOLD: prdata = {16'd0, cfg_reg.dropped_hold_ticks};
            default:          prdata = {16'd0, cfg_reg.blink_period_ticks};
        endcase
    end

    // hold the item until the result queue can take both writes
    assign process  = item_valid_reg && room;
    assign in_stall = item_valid_reg && !room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_valid && !in_stall)
        begin
            item_valid_reg <= 1'b1;
        end
        else if (process)
        begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg <= in_data;
        end
    end

    assign is_tick    = process && !item_reg.func;
    assign is_evt     = process && item_reg.func;
    assign code       = ev_code_e'(item_reg.event_req);
    assign suppressed = item_reg.version_shown || disabled_reg;

    assign ctl0 = '{tick: is_tick, evt: is_evt && !item_reg.port, code: code};
    assign ctl1 = '{tick: is_tick, evt: is_evt && item_reg.port, code: code};

    lllm_port u_port0 (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .ctl     (ctl0),
        .setting (setting0)
    );

    lllm_port u_port1 (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .ctl     (ctl1),
        .setting (setting1)
    );

    assign shown0 = shown_color(setting0, pwm_reg, blink_reg, cfg_reg.blink_period_ticks);
    assign shown1 = shown_color(setting1, pwm_reg, blink_reg, cfg_reg.blink_period_ticks);

    always_comb
    begin
        pwm_next        = pwm_reg;
        blink_next      = blink_reg;
        test_mode_next  = test_mode_reg;
        disabled_next   = disabled_reg;
        test_color_next = test_color_reg;
        test_cnt_next   = test_cnt_reg;
        push            = '0;
        if (is_tick)
        begin
            pwm_next   = (pwm_reg == PWM_W'(1)) ? PWM_W'(PWM_STEPS) : pwm_reg - PWM_W'(1);
            blink_next = (blink_reg == 16'd1) ? cfg_reg.blink_period_ticks
                                              : blink_reg - 16'd1;
            if (test_mode_reg)
            begin
                if (test_cnt_reg == 14'd1)
                begin
                    test_cnt_next   = TEST_PERIOD;
                    test_color_next = test_color_reg + 8'd1;
                end
                else
                begin
                    test_cnt_next = test_cnt_reg - 14'd1;
                end
                push.cnt = 2'd2;
                push.r0  = '{led_port: 1'b0, led_color: test_color_next, last: 1'b0};
                push.r1  = '{led_port: 1'b1, led_color: test_color_next, last: 1'b1};
            end
            else if (!suppressed)
            begin
                push.cnt = 2'd2;
                push.r0  = '{led_port: 1'b0, led_color: shown0, last: 1'b0};
                push.r1  = '{led_port: 1'b1, led_color: shown1, last: 1'b1};
            end
        end
        if (is_evt)
        begin
            unique case (code)
                EV_TEST:    test_mode_next = 1'b1;
                EV_DISABLE: disabled_next  = 1'b1;
                EV_UNPOWERED, EV_POWERED, EV_OFFLINE: blink_next = BLINK_FIRST;
                EV_START:
                begin
                    if (!suppressed)
                    begin
                        push.cnt = 2'd1;
                        push.r0  = '{led_port: item_reg.port,
                                     led_color: (item_reg.port ? shown1 : shown0),
                                     last: 1'b1};
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pwm_reg        <= PWM_W'(PWM_STEPS);
            blink_reg      <= BLINK_RESET;
            test_mode_reg  <= 1'b0;
            disabled_reg   <= 1'b0;
            test_color_reg <= TEST_COLOR_RESET;
            test_cnt_reg   <= TEST_PERIOD;
        end
        else
        begin
            pwm_reg        <= pwm_next;
            blink_reg      <= blink_next;
            test_mode_reg  <= test_mode_next;
            disabled_reg   <= disabled_next;
            test_color_reg <= test_color_next;
            test_cnt_reg   <= test_cnt_next;
        end
    end

    lllm_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    `ASSERT_CLK(a_test_sticky, test_mode_reg |=> test_mode_reg, "test mode left")
    `ASSERT_CLK(a_test_tick_two, (is_tick && test_mode_reg) |-> (push.cnt == 2'd2), "test tick without two writes")

endmodule
